@@ rtl/core/tfq_pkg.sv @@
// ----------------------------------------------------------------------------
// tfq_pkg
// Shared constants and types for the transform-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package tfq_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int Q_W       = FRAC_BITS + 3;

  // square root unit
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQRT_LAT  = ROOT_W;

  // divider unit
  localparam int QUO_BITS  = FRAC_BITS + 2;
  localparam int NUM_W     = 50;
  localparam int DEN_W     = 34;
  localparam int DIV_LAT   = QUO_BITS + 2;

  // configuration
  localparam int TOL_W                 = FRAC_BITS + 1;
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(66);
  localparam logic REG_TOL             = 1'b0;

  // quaternion case codes
  localparam logic [1:0] CASE_W = 2'd0;
  localparam logic [1:0] CASE_X = 2'd1;
  localparam logic [1:0] CASE_Y = 2'd2;
  localparam logic [1:0] CASE_Z = 2'd3;

  typedef logic signed [Q_W-1:0] q_t;

  // divider request
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
  } div_req_t;

  // normalized rotation with its case selection
  typedef struct packed {
    logic [1:0] sel;
    q_t [8:0]   c;
  } rot_t;

endpackage

@@ rtl/core/tfq_sqrt.sv @@
// ----------------------------------------------------------------------------
// tfq_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module tfq_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tfq_pkg::RAD_W-1:0]  rad,
  output logic [tfq_pkg::ROOT_W-1:0] root
);

  localparam int NS = tfq_pkg::SQRT_LAT;

  logic [tfq_pkg::REM_W-1:0]  rem_q   [NS];
  logic [tfq_pkg::ROOT_W-1:0] root_q  [NS];
  logic [tfq_pkg::RAD_W-1:0]  rad_q   [NS];
  logic [tfq_pkg::REM_W-1:0]  rem_nx  [NS];
  logic [tfq_pkg::ROOT_W-1:0] root_nx [NS];
  logic [tfq_pkg::RAD_W-1:0]  rad_nx  [NS];

  // one digit step per stage: bring down two radicand bits, try 4*root+1
  always_comb begin
    logic [tfq_pkg::REM_W-1:0]  r_in, r_sh, trial;
    logic [tfq_pkg::ROOT_W-1:0] q_in;
    logic [tfq_pkg::RAD_W-1:0]  v_in;
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        r_in = '0;
        q_in = '0;
        v_in = rad;
      end else begin
        r_in = rem_q[i-1];
        q_in = root_q[i-1];
        v_in = rad_q[i-1];
      end
      r_sh  = {r_in[tfq_pkg::REM_W-3:0], v_in[tfq_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, q_in, 2'b01};
      if (r_sh >= trial) begin
        rem_nx[i]  = r_sh - trial;
        root_nx[i] = {q_in[tfq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nx[i]  = r_sh;
        root_nx[i] = {q_in[tfq_pkg::ROOT_W-2:0], 1'b0};
      end
      rad_nx[i] = {v_in[tfq_pkg::RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        rem_q[i]  <= rem_nx[i];
        root_q[i] <= root_nx[i];
        rad_q[i]  <= rad_nx[i];
      end
    end
  end

  assign root = root_q[NS-1];

endmodule

@@ rtl/core/tfq_div.sv @@
// ----------------------------------------------------------------------------
// tfq_div
// Pipelined restoring divider with overflow check, sign and saturation.
// ----------------------------------------------------------------------------
module tfq_div (
  input  logic              clk,
  input  logic              en,
  input  tfq_pkg::div_req_t req,
  output tfq_pkg::q_t       quo
);

  localparam int NB  = tfq_pkg::QUO_BITS;
  localparam int NS  = NB + 1;
  localparam int CW  = tfq_pkg::NUM_W + 2;
  localparam logic [NB-1:0] LIM = NB'(1) << (tfq_pkg::FRAC_BITS + 1);

  logic [tfq_pkg::NUM_W-1:0] rem_q [NS];
  logic [tfq_pkg::DEN_W-1:0] den_q [NS];
  logic [NB-1:0]             q_q   [NS];
  logic                      neg_q [NS];
  logic                      zero_q[NS];
  logic                      ovf_q [NS];
  logic [tfq_pkg::NUM_W-1:0] rem_nx[NS];
  logic [NB-1:0]             q_nx  [NS];
  logic                      ovf0;
  logic [NB-1:0]             mag;
  logic [tfq_pkg::Q_W-1:0]   mag_x;

  // stage 0 flags quotients of 2^NB or more; stage s resolves bit NB-s
  always_comb begin
    logic [CW-1:0] sub;
    ovf0 = {2'b00, req.num} >= (CW'(req.den) << NB);
    rem_nx[0] = req.num;
    q_nx[0]   = '0;
    for (int s = 1; s < NS; s++) begin
      sub = CW'(den_q[s-1]) << (NB - s);
      if (!ovf_q[s-1] && ({2'b00, rem_q[s-1]} >= sub)) begin
        rem_nx[s] = rem_q[s-1] - sub[tfq_pkg::NUM_W-1:0];
        q_nx[s]   = q_q[s-1] | (NB'(1) << (NB - s));
      end else begin
        rem_nx[s] = rem_q[s-1];
        q_nx[s]   = q_q[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= rem_nx[0];
      q_q[0]    <= q_nx[0];
      den_q[0]  <= req.den;
      neg_q[0]  <= req.neg;
      zero_q[0] <= req.zero;
      ovf_q[0]  <= ovf0;
      for (int s = 1; s < NS; s++) begin
        rem_q[s]  <= rem_nx[s];
        q_q[s]    <= q_nx[s];
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
    end
  end

  // clamp to +-2.0, zero divisor gives zero, then apply sign
  always_comb begin
    if (zero_q[NS-1]) begin
      mag = '0;
    end else if (ovf_q[NS-1] || (q_q[NS-1] > LIM)) begin
      mag = LIM;
    end else begin
      mag = q_q[NS-1];
    end
    mag_x = {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_q[NS-1] ? -$signed(mag_x) : $signed(mag_x);
    end
  end

endmodule

@@ rtl/core/transform_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// transform_to_quaternion
// Splits an affine transform into position, quaternion and a scale warning.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    col0..col2 xyz, trans xyz
//  output    out        out_valid / out_ready  pos xyz, quat xyzw, scale_flag
//  config    in         APB psel/penable       scale_tolerance at byte 0
//
// One transaction per cycle while the pipe is not stalled; each result passes through
// two 32-stage square root units and two 20-stage dividers in series.
// Synchronous reset clears the valid bits and out_valid and sets the tolerance to 66.
// A waiting result stalls the pipe only when its last stage holds an item;
// bubbles keep moving so input is still taken while the output waits.
// ----------------------------------------------------------------------------
module transform_to_quaternion (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  col0_x,
  input  logic signed [31:0]  col0_y,
  input  logic signed [31:0]  col0_z,
  input  logic signed [31:0]  col1_x,
  input  logic signed [31:0]  col1_y,
  input  logic signed [31:0]  col1_z,
  input  logic signed [31:0]  col2_x,
  input  logic signed [31:0]  col2_y,
  input  logic signed [31:0]  col2_z,
  input  logic signed [31:0]  trans_x,
  input  logic signed [31:0]  trans_y,
  input  logic signed [31:0]  trans_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic signed [18:0]  quat_x,
  output logic signed [18:0]  quat_y,
  output logic signed [18:0]  quat_z,
  output logic signed [18:0]  quat_w,
  output logic                scale_flag
);

  localparam int PIPE      = 110;
  localparam int MS_DLY    = 33;
  localparam int TRANS_DLY = 109;
  localparam int FLAG_DLY  = 74;
  localparam int ROT_DLY   = 32;
  localparam int HALF_DLY  = 20;
  localparam int ONE       = 1 << tfq_pkg::FRAC_BITS;
  localparam int IW        = tfq_pkg::IN_W;
  localparam int TW        = 3 * IW;

  logic                          en;
  logic [PIPE-1:0]               vld;
  logic [tfq_pkg::TOL_W-1:0]     tol;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tfq_pkg::REG_TOL) ? 32'(tol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= tfq_pkg::TOL_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == tfq_pkg::REG_TOL)) begin
      tol <= pwdata[tfq_pkg::TOL_W-1:0];
    end
  end

  // pipe advances unless the last stage holds an item that cannot leave
  assign en       = out_ready || !out_valid || !vld[PIPE-1];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE-2:0], in_valid};
    end
  end

  // stage 1: input registers
  logic signed [IW-1:0] c_in [9];
  logic [TW-1:0]        trans_in;

  always_ff @(posedge clk) begin
    if (en) begin
      c_in[0]  <= col0_x;
      c_in[1]  <= col0_y;
      c_in[2]  <= col0_z;
      c_in[3]  <= col1_x;
      c_in[4]  <= col1_y;
      c_in[5]  <= col1_z;
      c_in[6]  <= col2_x;
      c_in[7]  <= col2_y;
      c_in[8]  <= col2_z;
      trans_in <= {trans_x, trans_y, trans_z};
    end
  end

  // stage 2: magnitudes and squares
  logic [IW-1:0]   mag_s [9];
  logic            sgn_s [9];
  logic [2*IW-1:0] sq_s  [9];
  logic [IW-1:0]   mag_c [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mag_c[k] = c_in[k][IW-1] ? IW'(-c_in[k]) : IW'(c_in[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        mag_s[k] <= mag_c[k];
        sgn_s[k] <= c_in[k][IW-1];
        sq_s[k]  <= mag_c[k] * mag_c[k];
      end
    end
  end

  // stage 3: squared column lengths
  logic [tfq_pkg::RAD_W-1:0] sum_s [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sum_s[i] <= sq_s[3*i] + sq_s[3*i+1] + sq_s[3*i+2];
      end
    end
  end

  // column lengths
  logic [tfq_pkg::ROOT_W-1:0] len [3];

  for (genvar i = 0; i < 3; i++) begin : g_len
    tfq_sqrt u_len (
      .clk  (clk),
      .en   (en),
      .rad  (sum_s[i]),
      .root (len[i])
    );
  end

  // magnitudes and signs wait for the lengths
  logic [IW-1:0] mag_dl [MS_DLY][9];
  logic          sgn_dl [MS_DLY][9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        mag_dl[0][k] <= mag_s[k];
        sgn_dl[0][k] <= sgn_s[k];
      end
      for (int d = 1; d < MS_DLY; d++) begin
        mag_dl[d] <= mag_dl[d-1];
        sgn_dl[d] <= sgn_dl[d-1];
      end
    end
  end

  // scale test and normalization requests
  tfq_pkg::div_req_t nreq_c [9];
  tfq_pkg::div_req_t nreq   [9];
  logic              flag_c;
  logic              flag_s;

  always_comb begin
    logic signed [IW:0] dev;
    logic [IW:0]        dev_abs;
    flag_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dev     = $signed({1'b0, len[i]}) - (IW+1)'(ONE);
      dev_abs = dev[IW] ? (IW+1)'(-dev) : (IW+1)'(dev);
      if (dev_abs > (IW+1)'(tol)) begin
        flag_c = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
        nreq_c[3*i+j].num  = (tfq_pkg::NUM_W'(mag_dl[MS_DLY-1][3*i+j])
                              << (tfq_pkg::FRAC_BITS + 1))
                             + tfq_pkg::NUM_W'(len[i]);
        nreq_c[3*i+j].den  = tfq_pkg::DEN_W'(len[i]) << 1;
        nreq_c[3*i+j].neg  = sgn_dl[MS_DLY-1][3*i+j];
        nreq_c[3*i+j].zero = (len[i] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nreq   <= nreq_c;
      flag_s <= flag_c;
    end
  end

  // normalized components
  tfq_pkg::q_t cn [9];

  for (genvar k = 0; k < 9; k++) begin : g_norm
    tfq_div u_norm (
      .clk (clk),
      .en  (en),
      .req (nreq[k]),
      .quo (cn[k])
    );
  end

  // case selection and root argument
  tfq_pkg::rot_t             rot_c, rot_s;
  logic [tfq_pkg::RAD_W-1:0] rad_c, rad_s;

  always_comb begin
    logic signed [tfq_pkg::Q_W+1:0] tr;
    logic signed [tfq_pkg::Q_W+2:0] arg;
    tr = cn[0] + cn[4] + cn[8];
    for (int k = 0; k < 9; k++) begin
      rot_c.c[k] = cn[k];
    end
    priority if (tr > 0) begin
      rot_c.sel = tfq_pkg::CASE_W;
      arg = (tfq_pkg::Q_W+3)'(ONE) + tr;
    end else if ((cn[0] > cn[4]) && (cn[0] > cn[8])) begin
      rot_c.sel = tfq_pkg::CASE_X;
      arg = (tfq_pkg::Q_W+3)'(ONE) + cn[0] - cn[4] - cn[8];
    end else if (cn[4] > cn[8]) begin
      rot_c.sel = tfq_pkg::CASE_Y;
      arg = (tfq_pkg::Q_W+3)'(ONE) + cn[4] - cn[0] - cn[8];
    end else begin
      rot_c.sel = tfq_pkg::CASE_Z;
      arg = (tfq_pkg::Q_W+3)'(ONE) + cn[8] - cn[0] - cn[4];
    end
    if (arg[tfq_pkg::Q_W+2]) begin
      rad_c = '0;
    end else begin
      rad_c = tfq_pkg::RAD_W'(arg[tfq_pkg::Q_W+1:0]) << tfq_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_s <= rot_c;
      rad_s <= rad_c;
    end
  end

  // quaternion root
  logic [tfq_pkg::ROOT_W-1:0] qr;

  tfq_sqrt u_qroot (
    .clk  (clk),
    .en   (en),
    .rad  (rad_s),
    .root (qr)
  );

  tfq_pkg::rot_t rot_dl [ROT_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      rot_dl[0] <= rot_s;
      for (int d = 1; d < ROT_DLY; d++) begin
        rot_dl[d] <= rot_dl[d-1];
      end
    end
  end

  // quotient requests: slot 0 is w unless w is the root component
  tfq_pkg::rot_t              rd;
  logic signed [tfq_pkg::Q_W:0] dif [3];
  tfq_pkg::div_req_t          qreq_c [3];
  tfq_pkg::div_req_t          qreq   [3];
  tfq_pkg::q_t                half_c, half_s;
  logic [1:0]                 sel_s;

  assign rd = rot_dl[ROT_DLY-1];

  always_comb begin
    logic [tfq_pkg::Q_W:0] m;
    unique case (rd.sel)
      tfq_pkg::CASE_W: begin
        dif[0] = rd.c[5] - rd.c[7];
        dif[1] = rd.c[6] - rd.c[2];
        dif[2] = rd.c[1] - rd.c[3];
      end
      tfq_pkg::CASE_X: begin
        dif[0] = rd.c[5] - rd.c[7];
        dif[1] = rd.c[1] + rd.c[3];
        dif[2] = rd.c[2] + rd.c[6];
      end
      tfq_pkg::CASE_Y: begin
        dif[0] = rd.c[6] - rd.c[2];
        dif[1] = rd.c[1] + rd.c[3];
        dif[2] = rd.c[5] + rd.c[7];
      end
      default: begin
        dif[0] = rd.c[1] - rd.c[3];
        dif[1] = rd.c[2] + rd.c[6];
        dif[2] = rd.c[5] + rd.c[7];
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      m = dif[k][tfq_pkg::Q_W] ? (tfq_pkg::Q_W+1)'(-dif[k])
                               : (tfq_pkg::Q_W+1)'(dif[k]);
      qreq_c[k].num  = (tfq_pkg::NUM_W'(m) << (tfq_pkg::FRAC_BITS + 1))
                       + (tfq_pkg::NUM_W'(qr) << 1);
      qreq_c[k].den  = tfq_pkg::DEN_W'(qr) << 2;
      qreq_c[k].neg  = dif[k][tfq_pkg::Q_W];
      qreq_c[k].zero = (qr == '0);
    end
    half_c = tfq_pkg::Q_W'(((tfq_pkg::ROOT_W+1)'(qr) + 1'b1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qreq   <= qreq_c;
      half_s <= half_c;
      sel_s  <= rd.sel;
    end
  end

  tfq_pkg::q_t qq [3];

  for (genvar k = 0; k < 3; k++) begin : g_quot
    tfq_div u_quot (
      .clk (clk),
      .en  (en),
      .req (qreq[k]),
      .quo (qq[k])
    );
  end

  // side data delay lines
  logic [TW-1:0] trans_dl [TRANS_DLY];
  logic          flag_dl  [FLAG_DLY];
  tfq_pkg::q_t   half_dl  [HALF_DLY];
  logic [1:0]    sel_dl   [HALF_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      trans_dl[0] <= trans_in;
      for (int d = 1; d < TRANS_DLY; d++) begin
        trans_dl[d] <= trans_dl[d-1];
      end
      flag_dl[0] <= flag_s;
      for (int d = 1; d < FLAG_DLY; d++) begin
        flag_dl[d] <= flag_dl[d-1];
      end
      half_dl[0] <= half_s;
      sel_dl[0]  <= sel_s;
      for (int d = 1; d < HALF_DLY; d++) begin
        half_dl[d] <= half_dl[d-1];
        sel_dl[d]  <= sel_dl[d-1];
      end
    end
  end

  // output register
  tfq_pkg::q_t hf;
  logic [1:0]  sl;

  assign hf = half_dl[HALF_DLY-1];
  assign sl = sel_dl[HALF_DLY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid <= vld[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      pos_x      <= trans_dl[TRANS_DLY-1][3*IW-1 -: IW];
      pos_y      <= trans_dl[TRANS_DLY-1][2*IW-1 -: IW];
      pos_z      <= trans_dl[TRANS_DLY-1][IW-1:0];
      scale_flag <= flag_dl[FLAG_DLY-1];
      unique case (sl)
        tfq_pkg::CASE_W: begin
          quat_w <= hf;    quat_x <= qq[0]; quat_y <= qq[1]; quat_z <= qq[2];
        end
        tfq_pkg::CASE_X: begin
          quat_x <= hf;    quat_w <= qq[0]; quat_y <= qq[1]; quat_z <= qq[2];
        end
        tfq_pkg::CASE_Y: begin
          quat_y <= hf;    quat_w <= qq[0]; quat_x <= qq[1]; quat_z <= qq[2];
        end
        default: begin
          quat_z <= hf;    quat_w <= qq[0]; quat_x <= qq[1]; quat_y <= qq[2];
        end
      endcase
    end
  end

endmodule

@@ rtl/core/tfq_checker.sv @@
// ----------------------------------------------------------------------------
// tfq_checker
// Port-level checks for transform_to_quaternion, bound to the top level.
// ----------------------------------------------------------------------------
module tfq_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] quat_x,
  input logic signed [18:0] quat_y,
  input logic signed [18:0] quat_z,
  input logic signed [18:0] quat_w
);

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds its transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_y)
      && $stable(quat_z) && $stable(quat_w))
    else $error("stalled result changed");

  // quaternion components stay within +-2.0
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_x >= -19'sd131072) && (quat_x <= 19'sd131072)
      && (quat_y >= -19'sd131072) && (quat_y <= 19'sd131072)
      && (quat_z >= -19'sd131072) && (quat_z <= 19'sd131072)
      && (quat_w >= -19'sd131072) && (quat_w <= 19'sd131072))
    else $error("quaternion out of range");

  // an empty output never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind transform_to_quaternion tfq_checker u_tfq_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for transform_to_quaternion: directed and random
// transforms are pushed through the valid/ready input. A built-in predictor
// computes position, quaternion and scale flag per transaction, and the
// monitor compares every result in order. The tolerance register is swept
// over several values through the APB port while the pipe is drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 111;
  localparam int MAX_CYC   = 2000000;
  localparam longint ONE   = 64'sd1 <<< tfq_pkg::FRAC_BITS;

  typedef struct {
    logic signed [31:0] c [9];
    logic signed [31:0] t [3];
  } xform_t;

  typedef struct {
    logic signed [31:0] p [3];
    logic signed [18:0] q [4];
    logic               flag;
  } pose_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [31:0] cin [9];
  logic signed [31:0] tin [3];
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [18:0] quat_x, quat_y, quat_z, quat_w;
  logic scale_flag;

  xform_t pending_xforms [$];
  pose_t  expected_poses [$];
  logic [tfq_pkg::TOL_W-1:0] tol_model = tfq_pkg::TOL_RST;
  logic [tfq_pkg::TOL_W-1:0] tol_model_list [5] =
    '{17'd0, 17'd66, 17'd65536, 17'd1000, 17'h1ffff};
  int errors = 0, checked = 0, cycles = 0, sent = 0;
  int in_gap = 0, out_gap = 0;
  bit stall_on = 1, hold_input = 0;

  initial for (int i = 0; i < 9; i++) cin[i] = '0;
  initial for (int i = 0; i < 3; i++) tin[i] = '0;

  transform_to_quaternion dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready,
    .col0_x(cin[0]), .col0_y(cin[1]), .col0_z(cin[2]),
    .col1_x(cin[3]), .col1_y(cin[4]), .col1_z(cin[5]),
    .col2_x(cin[6]), .col2_y(cin[7]), .col2_z(cin[8]),
    .trans_x(tin[0]), .trans_y(tin[1]), .trans_z(tin[2]),
    .out_valid, .out_ready, .pos_x, .pos_y, .pos_z,
    .quat_x, .quat_y, .quat_z, .quat_w, .scale_flag
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rounded divide, ties away from zero, zero divisor gives 0
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    if (den == 0) return 0;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned quat_root(longint arg);
    if (arg < 0) arg = 0;
    return isqrt(longint'(arg) * ONE);
  endfunction

  function automatic logic signed [18:0] clamp2(longint v);
    if (v > 2 * ONE) v = 2 * ONE;
    if (v < -2 * ONE) v = -2 * ONE;
    return v[18:0];
  endfunction

  function automatic pose_t decompose(xform_t x);
    pose_t o;
    longint m [9];
    longint qx, qy, qz, qw, a, b, d;
    longint unsigned sum, len, r, den;
    longint dev, v;
    logic flag;
    flag = 0;
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        v = x.c[i*3+j];
        m[i*3+j] = v;
        sum += longint'(v < 0 ? -v : v) * longint'(v < 0 ? -v : v);
      end
      len = isqrt(sum);
      dev = longint'(len) - ONE;
      if (dev < 0) dev = -dev;
      if (dev > longint'(tol_model)) flag = 1;
      if (len > 0)
        for (int j = 0; j < 3; j++) m[i*3+j] = round_div(m[i*3+j] * ONE, len);
    end
    a = m[0]; b = m[4]; d = m[8];
    // trace test, then largest-diagonal cases
    if (a + b + d > 0) begin
      r = quat_root(a + b + d + ONE); den = 2 * r;
      qw = round_div(longint'(r), 2);
      qx = round_div((m[5] - m[7]) * ONE, den);
      qy = round_div((m[6] - m[2]) * ONE, den);
      qz = round_div((m[1] - m[3]) * ONE, den);
    end else if (a > b && a > d) begin
      r = quat_root(ONE + a - b - d); den = 2 * r;
      qx = round_div(longint'(r), 2);
      qw = round_div((m[5] - m[7]) * ONE, den);
      qy = round_div((m[1] + m[3]) * ONE, den);
      qz = round_div((m[2] + m[6]) * ONE, den);
    end else if (b > d) begin
      r = quat_root(ONE + b - a - d); den = 2 * r;
      qy = round_div(longint'(r), 2);
      qw = round_div((m[6] - m[2]) * ONE, den);
      qx = round_div((m[1] + m[3]) * ONE, den);
      qz = round_div((m[5] + m[7]) * ONE, den);
    end else begin
      r = quat_root(ONE + d - a - b); den = 2 * r;
      qz = round_div(longint'(r), 2);
      qw = round_div((m[1] - m[3]) * ONE, den);
      qx = round_div((m[2] + m[6]) * ONE, den);
      qy = round_div((m[5] + m[7]) * ONE, den);
    end
    o.p = x.t;
    o.q[0] = clamp2(qx); o.q[1] = clamp2(qy);
    o.q[2] = clamp2(qz); o.q[3] = clamp2(qw);
    o.flag = flag;
    return o;
  endfunction

  // input driver
  always @(posedge clk) begin
    xform_t x;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_poses.push_back(decompose(pending_xforms.pop_front()));
        sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pending_xforms.size() > 0 && !hold_input) begin
          x = pending_xforms[0];
          in_valid <= 1;
          cin <= x.c;
          tin <= x.t;
          if (stall_on && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    pose_t e;
    logic signed [31:0] gp [3];
    logic signed [18:0] gq [4];
    cycles++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        gp = '{pos_x, pos_y, pos_z};
        gq = '{quat_x, quat_y, quat_z, quat_w};
        if (expected_poses.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction");
        end else begin
          e = expected_poses.pop_front();
          checked++;
          if (gp != e.p || gq != e.q || scale_flag != e.flag) begin
            errors++;
            if (errors <= 10)
              $display("mismatch #%0d: exp pos %0d %0d %0d q %0d %0d %0d %0d f %0b",
                       checked, e.p[0], e.p[1], e.p[2], e.q[0], e.q[1], e.q[2],
                       e.q[3], e.flag, "\n  got pos %0d %0d %0d q %0d %0d %0d %0d f %0b",
                       gp[0], gp[1], gp[2], gq[0], gq[1], gq[2], gq[3], scale_flag);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (stall_on && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 12);
      end
    end
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic tol_write(logic [tfq_pkg::TOL_W-1:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {tfq_pkg::REG_TOL, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    tol_model = val;
  endtask

  task automatic drain();
    wait (pending_xforms.size() == 0 && expected_poses.size() == 0 && !in_valid);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return $signed($urandom_range(0, 2 * 65536)) - 65536;
    endcase
  endfunction

  // near-rotation with random scale and noise, plus permuted/signed axes; sometimes random words or a zero column
  function automatic xform_t rnd_xform();
    xform_t x;
    int perm, sc;
    perm = $urandom_range(0, 5);
    for (int i = 0; i < 3; i++) x.t[i] = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 9; i++) x.c[i] = rnd_word();
    end else begin
      for (int i = 0; i < 9; i++) x.c[i] = $signed($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < 3; i++) begin
        sc = ($urandom_range(0, 1)) ? 65536 : $urandom_range(1, 400000);
        x.c[i*3 + (i + perm) % 3] += ($urandom_range(0, 1) ? sc : -sc);
      end
      if ($urandom_range(0, 20) == 0) for (int j = 0; j < 3; j++) x.c[j] = 0;
    end
    return x;
  endfunction

  function automatic xform_t diag_xform(int a, int b, int d);
    xform_t x;
    for (int i = 0; i < 9; i++) x.c[i] = 0;
    x.c[0] = a; x.c[4] = b; x.c[8] = d;
    x.t = '{32'sh7fff_ffff, 32'sh8000_0000, 0};
    return x;
  endfunction

  initial begin
    xform_t x;
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed: identity, each diagonal case, zero and extreme columns
    pending_xforms.push_back(diag_xform(65536, 65536, 65536));
    pending_xforms.push_back(diag_xform(65536, -65536, -65536));
    pending_xforms.push_back(diag_xform(-65536, 65536, -65536));
    pending_xforms.push_back(diag_xform(-65536, -65536, 65536));
    pending_xforms.push_back(diag_xform(-65536, -65536, -65536));
    pending_xforms.push_back(diag_xform(0, 0, 0));
    pending_xforms.push_back(diag_xform(65602, 65536, 65470));
    pending_xforms.push_back(diag_xform(65603, 65536, 65469));
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++)
        x.c[i] = (k == 0) ? 32'sh8000_0000 : (k == 1) ? 32'sh7fff_ffff :
                 (k == 2) ? -1 : ((i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff);
      x.t = '{-1, 0, 1};
      pending_xforms.push_back(x);
    end
    // 90 degree turns about each axis
    x = diag_xform(65536, 0, 0); x.c[5] = 65536; x.c[7] = -65536;
    pending_xforms.push_back(x);
    x = diag_xform(0, 65536, 0); x.c[6] = 65536; x.c[2] = -65536;
    pending_xforms.push_back(x);
    x = diag_xform(0, 0, 65536); x.c[1] = 65536; x.c[3] = -65536;
    pending_xforms.push_back(x);
    drain();
    // random phases over several tolerance settings
    foreach (tol_model_list[p]) begin
      tol_write(tol_model_list[p]);
      for (int n = 0; n < 200; n++) pending_xforms.push_back(rnd_xform());
      if (p == 1) begin
        wait (pending_xforms.size() < 100);
        hold_input = 1;
        wait (expected_poses.size() == 0);
        hold_input = 0;
      end
      if (p == 4) stall_on = 0;
      drain();
    end
    $display("covered %0d transforms, %0d results checked, 5 tolerance settings",
             sent, checked);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tfq_pkg.sv
rtl/core/tfq_sqrt.sv
rtl/core/tfq_div.sv
rtl/core/transform_to_quaternion.sv
rtl/core/tfq_checker.sv
tb/tb_top.sv
